/* sv/cssm_pkg.sv */
// Shared types and codes for the codepoint set and sequence matcher.
`default_nettype none
package cssm_pkg;

    localparam int CP_W = 21;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_RANGE = 2'd1;
    localparam logic [1:0] OP_PATTERN = 2'd2;
    localparam logic [1:0] OP_MATCH = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE_FULL = 2'd1;
    localparam logic [1:0] ST_PATTERN_FULL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic latch;
        logic clear;
        logic exec_range;
        logic exec_pat;
        logic shift;
        logic r_read;
        logic r_cmp;
        logic l_read;
        logic p_next;
        logic k_start;
        logic e_read;
        logic e_cmp;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       last;
        logic       range_more;
        logic       pat_more;
        logic       len_ok;
        logic       elem_eq;
        logic       elem_end;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

/* sv/cssm_ctrl.sv */
// Sequencing state machine of the matcher.
`default_nettype none
module cssm_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire cssm_pkg::sts_t sts,
    output cssm_pkg::cmd_t     cmd
);
    import cssm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RRD  = 4'd2;
    localparam logic [3:0] S_RCMP = 4'd3;
    localparam logic [3:0] S_PSEL = 4'd4;
    localparam logic [3:0] S_PCHK = 4'd5;
    localparam logic [3:0] S_ERD  = 4'd6;
    localparam logic [3:0] S_ECMP = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_RANGE:
                    begin
                        cmd.exec_range = 1'b1;
                        state_next = S_EMIT;
                    end
                    OP_PATTERN:
                    begin
                        cmd.exec_pat = 1'b1;
                        state_next = sts.last ? S_EMIT : S_IDLE;
                    end
                    default:
                    begin
                        cmd.shift = 1'b1;
                        state_next = S_RRD;
                    end
                endcase
            end
            S_RRD:
            begin
                if (sts.range_more)
                begin
                    cmd.r_read = 1'b1;
                    state_next = S_RCMP;
                end
                else
                begin
                    state_next = S_PSEL;
                end
            end
            S_RCMP:
            begin
                cmd.r_cmp = 1'b1;
                state_next = S_RRD;
            end
            S_PSEL:
            begin
                if (sts.pat_more)
                begin
                    cmd.l_read = 1'b1;
                    state_next = S_PCHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PCHK:
            begin
                if (sts.len_ok)
                begin
                    cmd.k_start = 1'b1;
                    state_next = S_ERD;
                end
                else
                begin
                    cmd.p_next = 1'b1;
                    state_next = S_PSEL;
                end
            end
            S_ERD:
            begin
                cmd.e_read = 1'b1;
                state_next = S_ECMP;
            end
            S_ECMP:
            begin
                cmd.e_cmp = 1'b1;
                priority if (!sts.elem_eq || sts.elem_end)
                    state_next = S_PSEL;
                else
                    state_next = S_ERD;
            end
            S_FIN:
            begin
                if (sts.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* sv/cssm_dp.sv */
// Tables, target window, scan counters and result register of the matcher.
`default_nettype none
module cssm_dp
#(
    parameter int MAX_PATTERN_LEN = 16,
    parameter int PATTERN_SLOTS = 64,
    parameter int RANGE_SLOTS = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [1:0]               operation,
    input  wire logic [cssm_pkg::CP_W-1:0] codepoint,
    input  wire logic [cssm_pkg::CP_W-1:0] range_high,
    input  wire logic                     last,
    input  wire cssm_pkg::cmd_t           cmd,
    output cssm_pkg::sts_t                sts,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic                          found,
    output logic                          range_hit,
    output logic                          pattern_hit,
    output logic [1:0]                    status
);
    import cssm_pkg::*;

    localparam int KW  = (MAX_PATTERN_LEN > 2) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LW  = $clog2(MAX_PATTERN_LEN + 2);
    localparam int FW  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int RCW = $clog2(RANGE_SLOTS + 1);
    localparam int RIW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int PCW = $clog2(PATTERN_SLOTS + 1);
    localparam int PIW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
    localparam int PDEPTH = 2 ** (PIW + KW);
    localparam logic [LW:0] LEN_CAP = (LW + 1)'(MAX_PATTERN_LEN + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN_LEN);

    logic [1:0]      op_reg;
    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] hi_reg;
    logic            last_reg;

    logic [CP_W-1:0] window_reg [MAX_PATTERN_LEN];
    logic [FW-1:0]   fill_reg;
    logic [RCW-1:0]  rcount_reg;
    logic [PCW-1:0]  pcount_reg;
    logic [LW-1:0]   loadpos_reg;
    logic [1:0]      sticky_reg;
    logic [RCW-1:0]  ri_reg;
    logic [PCW-1:0]  pi_reg;
    logic [LW-1:0]   k_reg;

    logic [CP_W-1:0] rlo_q_reg;
    logic [CP_W-1:0] rhi_q_reg;
    logic [LW-1:0]   len_q_reg;
    logic [CP_W-1:0] elem_q_reg;
    logic [CP_W-1:0] tap_q_reg;

    logic [1:0] res_status_reg;
    logic       res_rhit_reg;
    logic       res_phit_reg;
    logic       out_valid_reg;
    logic       found_reg;
    logic       rhit_reg;
    logic       phit_reg;
    logic [1:0] status_reg;

    logic [2*CP_W-1:0] range_mem [RANGE_SLOTS];
    logic [CP_W-1:0]   pat_mem [PDEPTH];
    logic [LW-1:0]     len_mem [PATTERN_SLOTS];

    logic            range_full;
    logic            pat_full;
    logic [LW:0]     len_inc;
    logic [LW-1:0]   len_sat;
    logic            pat_wr;
    logic            range_wr;
    logic [CP_W-1:0] range_wr_hi;
    logic            len_wr;
    logic [1:0]      pat_status;
    logic [LW-1:0]   tap_idx;

    assign range_full = (rcount_reg >= RCW'(RANGE_SLOTS));
    assign pat_full   = (pcount_reg >= PCW'(PATTERN_SLOTS));
    assign len_inc    = {1'b0, loadpos_reg} + (LW + 1)'(1);
    assign len_sat    = (len_inc > LEN_CAP) ? LEN_CAP[LW-1:0] : len_inc[LW-1:0];
    assign pat_wr     = cmd.exec_pat && (loadpos_reg < LEN_MAX) && !pat_full;
    assign tap_idx    = len_q_reg - LW'(1) - k_reg;

    always_comb
    begin
        range_wr = 1'b0;
        range_wr_hi = hi_reg;
        len_wr = 1'b0;
        pat_status = ST_OK;
        if (cmd.exec_range)
        begin
            range_wr = !range_full;
        end
        if (cmd.exec_pat && last_reg)
        begin
            priority if (len_sat == LW'(1))
            begin
                range_wr = !range_full;
                range_wr_hi = cp_reg;
                pat_status = range_full ? ST_RANGE_FULL : ST_OK;
            end
            else if (len_sat > LEN_MAX)
                pat_status = ST_TOO_LONG;
            else if (pat_full)
                pat_status = ST_PATTERN_FULL;
            else
                len_wr = 1'b1;
        end
    end

    always_comb
    begin
        sts.op = op_reg;
        sts.last = last_reg;
        sts.range_more = !sticky_reg[0] && (ri_reg < rcount_reg);
        sts.pat_more = !sticky_reg[1] && (pi_reg < pcount_reg);
        sts.len_ok = ({{(LW - FW + 1){1'b0}}, fill_reg} >= {1'b0, len_q_reg});
        sts.elem_eq = (elem_q_reg == tap_q_reg);
        sts.elem_end = ((k_reg + LW'(1)) == len_q_reg);
        sts.out_free = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk)
    begin
        if (range_wr)
            range_mem[rcount_reg[RIW-1:0]] <= {range_wr_hi, cp_reg};
        if (cmd.r_read)
            {rhi_q_reg, rlo_q_reg} <= range_mem[ri_reg[RIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pat_wr)
            pat_mem[{pcount_reg[PIW-1:0], loadpos_reg[KW-1:0]}] <= cp_reg;
        if (cmd.e_read)
            elem_q_reg <= pat_mem[{pi_reg[PIW-1:0], k_reg[KW-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (len_wr)
            len_mem[pcount_reg[PIW-1:0]] <= len_sat;
        if (cmd.l_read)
            len_q_reg <= len_mem[pi_reg[PIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cp_reg <= codepoint;
            hi_reg <= range_high;
        end
        if (cmd.e_read)
            tap_q_reg <= window_reg[tap_idx[KW-1:0]];
        if (cmd.exec_range)
        begin
            res_status_reg <= range_full ? ST_RANGE_FULL : ST_OK;
            res_rhit_reg <= 1'b0;
            res_phit_reg <= 1'b0;
        end
        if (cmd.exec_pat)
        begin
            res_status_reg <= pat_status;
            res_rhit_reg <= 1'b0;
            res_phit_reg <= 1'b0;
        end
        if (cmd.finish)
        begin
            res_status_reg <= ST_OK;
            res_rhit_reg <= sticky_reg[0];
            res_phit_reg <= sticky_reg[1];
        end
        if (cmd.emit)
        begin
            found_reg <= res_rhit_reg | res_phit_reg;
            rhit_reg <= res_rhit_reg;
            phit_reg <= res_phit_reg;
            status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_CLEAR;
            last_reg <= 1'b0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++)
                window_reg[i] <= '0;
            fill_reg <= '0;
            rcount_reg <= '0;
            pcount_reg <= '0;
            loadpos_reg <= '0;
            sticky_reg <= '0;
            ri_reg <= '0;
            pi_reg <= '0;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                op_reg <= operation;
                last_reg <= last;
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < MAX_PATTERN_LEN; i++)
                    window_reg[i] <= '0;
                fill_reg <= '0;
                rcount_reg <= '0;
                pcount_reg <= '0;
                loadpos_reg <= '0;
                sticky_reg <= '0;
            end
            if (range_wr)
                rcount_reg <= rcount_reg + RCW'(1);
            if (len_wr)
                pcount_reg <= pcount_reg + PCW'(1);
            if (cmd.exec_pat)
                loadpos_reg <= last_reg ? '0 : len_sat;
            if (cmd.shift)
            begin
                for (int i = MAX_PATTERN_LEN - 1; i > 0; i--)
                    window_reg[i] <= window_reg[i-1];
                window_reg[0] <= cp_reg;
                if (fill_reg < FW'(MAX_PATTERN_LEN))
                    fill_reg <= fill_reg + FW'(1);
                ri_reg <= '0;
                pi_reg <= '0;
            end
            if (cmd.r_cmp)
            begin
                if ((rlo_q_reg <= cp_reg) && (cp_reg <= rhi_q_reg))
                    sticky_reg[0] <= 1'b1;
                ri_reg <= ri_reg + RCW'(1);
            end
            if (cmd.p_next)
                pi_reg <= pi_reg + PCW'(1);
            if (cmd.k_start)
                k_reg <= '0;
            if (cmd.e_cmp)
            begin
                priority if (!sts.elem_eq)
                    pi_reg <= pi_reg + PCW'(1);
                else if (sts.elem_end)
                    sticky_reg[1] <= 1'b1;
                else
                    k_reg <= k_reg + LW'(1);
            end
            if (cmd.finish)
            begin
                sticky_reg <= '0;
                fill_reg <= '0;
                for (int i = 0; i < MAX_PATTERN_LEN; i++)
                    window_reg[i] <= '0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign found = found_reg;
    assign range_hit = rhit_reg;
    assign pattern_hit = phit_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

/* sv/codepoint_set_and_sequence_matcher.sv */
// Top level of the codepoint set and sequence matcher.
// Input channel: item_valid/item_stall with operation, codepoint, range_high
// and last. Result channel: result_valid/result_stall with found, range_hit,
// pattern_hit and status, held in an output register.
// Items are taken one at a time; item_stall is high while one is in work.
// A match codepoint is compared with each stored range, then with each
// stored pattern element by element; the scans walk the range and pattern
// memories through their single registered read ports, and
// stop early once the corresponding hit is already set for the target.
// A result sits in the output register until taken; a new item is accepted
// meanwhile, and a following result waits until the register frees.
// Reset (rst_n, asynchronous) empties both tables, the target window and
// any pending result. Table contents are not cleared; the counts gate them.
`default_nettype none
module codepoint_set_and_sequence_matcher
#(
    parameter int MAX_PATTERN_LEN = 16,
    parameter int PATTERN_SLOTS = 64,
    parameter int RANGE_SLOTS = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire logic [1:0]                operation,
    input  wire logic [cssm_pkg::CP_W-1:0] codepoint,
    input  wire logic [cssm_pkg::CP_W-1:0] range_high,
    input  wire logic                      last,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic                           found,
    output logic                           range_hit,
    output logic                           pattern_hit,
    output logic [1:0]                     status
);
    import cssm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cssm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    cssm_dp
    #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .PATTERN_SLOTS   (PATTERN_SLOTS),
        .RANGE_SLOTS     (RANGE_SLOTS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .codepoint    (codepoint),
        .range_high   (range_high),
        .last         (last),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .range_hit    (range_hit),
        .pattern_hit  (pattern_hit),
        .status       (status)
    );

endmodule
`default_nettype wire

/* sv/cssm_checker.sv */
// Port-level assertions for the matcher, bound to its top level.
`default_nettype none
module cssm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic       found,
    input wire logic       range_hit,
    input wire logic       pattern_hit,
    input wire logic [1:0] status
);
    import cssm_pkg::*;

    a_found_or: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (found == (range_hit | pattern_hit)))
        else $error("found differs from hit flags");

    a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> !found)
        else $error("hit reported on a load result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second transfer taken while item in work");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(found))
        else $error("stalled result changed");

endmodule

bind codepoint_set_and_sequence_matcher cssm_checker u_cssm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .range_hit    (range_hit),
    .pattern_hit  (pattern_hit),
    .status       (status)
);
`default_nettype wire
